### rtl/srs_pkg.sv
package srs_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_SORT = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic        [14:0] out_radius;
    logic               last;
  } out_item_t;

  // one stored sphere record
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic        [14:0] r;
  } rec_t;

endpackage

### rtl/sphere_radius_sorter.sv
// Load beat: taken in S_IDLE without leaving it, busy stays low, so loads can arrive every cycle.
// Sort beat: insertion sort over the record RAM through one compare unit and one
// RAM port, each record from the second on fetched (S_NEXT, S_HOLD) and moved down
// (S_CMP, S_PLACE); then n records stream out (none if empty), one result per cycle.
// Reset (rst_n low, synchronous) empties the store; the RAM contents are not cleared.
// Results are strobed for one cycle each, the last one flagged; no receiver stall.
module sphere_radius_sorter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srs_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output srs_pkg::out_item_t  out_item
);
  import srs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_HOLD,
    S_CMP,
    S_PLACE,
    S_EMIT,
    S_DRAIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [ADDR_W-1:0] e_r, e_nxt;
  rec_t              hold_r, hold_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_strobe_r;
  out_item_t         out_item_r;

  // record RAM, one write and one registered read per cycle
  rec_t              mem [CAPACITY];
  rec_t              rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_data;

  logic              accept;
  logic              rad_pos;
  logic              prev_ge;

  assign accept  = start && !busy;
  assign rad_pos = !in_item.radius[15] && (in_item.radius != 16'sd0);
  // shared compare: previous record moves up when its radius is not smaller
  assign prev_ge = rd_data_r.r >= hold_r.r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    hold_nxt      = hold_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    rd_addr       = e_r;
    wr_en         = 1'b0;
    wr_addr       = k_r;
    wr_data       = hold_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.kind == KIND_LOAD) begin
            // append if the radius is positive and there is room, else drop
            if (rad_pos && (count_r < CNT_W'(CAPACITY))) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[ADDR_W-1:0];
              wr_data.x = in_item.pos_x;
              wr_data.y = in_item.pos_y;
              wr_data.z = in_item.pos_z;
              wr_data.r = in_item.radius[14:0];
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            i_nxt     = CNT_W'(1);
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        // fetch the next record to insert, or move on to streaming
        if (i_r >= count_r) begin
          e_nxt     = '0;
          state_nxt = (count_r == '0) ? S_IDLE : S_EMIT;
        end else begin
          rd_addr   = i_r[ADDR_W-1:0];
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        hold_nxt  = rd_data_r;
        k_nxt     = i_r[ADDR_W-1:0];
        rd_addr   = i_r[ADDR_W-1:0] - ADDR_W'(1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        wr_en   = 1'b1;
        wr_addr = k_r;
        if (prev_ge) begin
          // shift the previous record up one slot
          wr_data = rd_data_r;
          k_nxt   = k_r - ADDR_W'(1);
          if (k_r == ADDR_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            rd_addr = k_r - ADDR_W'(2);
          end
        end else begin
          wr_data   = hold_r;
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_NEXT;
        end
      end
      S_PLACE: begin
        // drop the held record at the bottom
        wr_en     = 1'b1;
        wr_addr   = k_r;
        wr_data   = hold_r;
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_NEXT;
      end
      S_EMIT: begin
        rd_addr       = e_r;
        pend_nxt      = 1'b1;
        pend_last_nxt = (CNT_W'(e_r) + CNT_W'(1)) == count_r;
        e_nxt         = e_r + ADDR_W'(1);
        if (pend_last_nxt) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // RAM port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= pend_r;
    end
    i_r                   <= i_nxt;
    k_r                   <= k_nxt;
    e_r                   <= e_nxt;
    hold_r                <= hold_nxt;
    pend_last_r           <= pend_last_nxt;
    out_item_r.out_x      <= rd_data_r.x;
    out_item_r.out_y      <= rd_data_r.y;
    out_item_r.out_z      <= rd_data_r.z;
    out_item_r.out_radius <= rd_data_r.r;
    out_item_r.last       <= pend_last_r;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_cmp_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (k_r != '0))
    else $error("compare step with insert slot at zero");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == KIND_LOAD) |=> !busy)
    else $error("load beat did not complete in one cycle");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |=> !out_strobe)
    else $error("result after the last record of a run");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |=>
      (out_strobe && out_item.out_radius >= $past(out_item.out_radius)))
    else $error("run not contiguous or not ascending");

endmodule
